// ===== sv/ogsm_pkg.sv =====
// Shared constants, types and weight table for the occupancy splat map.
package ogsm_pkg;

  // Map geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HEIGHT_W   = ROW_W + 1;

  // Window geometry: 7x7, six rows kept in the line store
  localparam int WIN      = 7;
  localparam int HALF_WIN = 3;
  localparam int LS_W     = WIN - 1;

  // Warm-up count before the first result: 3 rows plus 3 cells
  localparam int CNT_W = $clog2(3 * MAX_WIDTH + 4);

  // Fixed point
  localparam int FRACTION_BITS = 15;
  localparam int WGT_W         = FRACTION_BITS;
  localparam int PSUM_W        = FRACTION_BITS + 1;
  localparam int SUM_W         = PSUM_W + 3;
  localparam int Q24_BITS      = 24;
  localparam int RND_SH        = Q24_BITS - FRACTION_BITS;
  localparam int RND_HALF      = (RND_SH == 0) ? 0 : (1 << (RND_SH - 1));

  // Port field widths
  localparam int PIXEL_W      = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int FIELD_W      = 16;
  localparam int ROW_FIELD_W  = 12;
  localparam int COL_FIELD_W  = 11;
  localparam int OUT_PAD_W    = 1;
  localparam int OUT_TDATA_W  = FIELD_W + ROW_FIELD_W + COL_FIELD_W + OUT_PAD_W;

  // Configuration port
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int OCC_CFG_W    = 8;
  localparam logic [OCC_CFG_W-1:0] OCC_DEFAULT = 8'd124;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH    = 2'd0,
    REG_MAP_HEIGHT   = 2'd1,
    REG_OCCUPIED_MAX = 2'd2
  } cfg_reg_t;

  // Broadcast control from the top level to every column cell
  typedef struct packed {
    logic           shift;
    logic           calc;
    logic [WIN-1:0] row_ok;
  } cell_ctl_t;

  // Q.24 weights exp(-(dy^2+dx^2)/4)/5, index |dy|*4 + |dx|
  localparam logic [Q24_BITS-1:0] WQ24 [16] = '{
    24'd3355443, 24'd2613222, 24'd1234399, 24'd353661,
    24'd2613222, 24'd2035179, 24'd961351,  24'd275432,
    24'd1234399, 24'd961351,  24'd454110,  24'd130105,
    24'd353661,  24'd275432,  24'd130105,  24'd37276
  };

  // Weight rounded half up to FRACTION_BITS fraction bits
  function automatic logic [WGT_W-1:0] weight(input logic [1:0] ady, input logic [1:0] adx);
    logic [Q24_BITS:0] tmp;
    tmp = {1'b0, WQ24[{ady, adx}]} + (Q24_BITS + 1)'(RND_HALF);
    return WGT_W'(tmp >> RND_SH);
  endfunction

endpackage

// ===== sv/ogsm_line_store.sv =====
// Line store: six rows of occupancy bits per column, read-modify-write per word.
module ogsm_line_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ogsm_pkg::COL_W-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic                       occ,
  output logic [ogsm_pkg::WIN-1:0]   vcol
);
  import ogsm_pkg::*;

  logic [LS_W-1:0]  mem_r [MAX_WIDTH];
  logic [COL_W-1:0] addr_r;
  logic [LS_W-1:0]  rdata_r;
  logic [COL_W-1:0] fwd_addr_r;
  logic [LS_W-1:0]  fwd_data_r;
  logic             fwd_vld_r;
  logic [LS_W-1:0]  ls_cur;
  logic [LS_W-1:0]  ls_nxt;

  // Last write is forwarded when the next word hits the same column
  always_comb begin
    ls_cur = (fwd_vld_r && (fwd_addr_r == addr_r)) ? fwd_data_r : rdata_r;
    ls_nxt = {ls_cur[LS_W-2:0], occ};
    for (int j = 0; j < LS_W; j++) begin
      vcol[j] = ls_cur[LS_W-1-j];
    end
    vcol[LS_W] = occ;
  end

  // Memory: one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
      addr_r  <= rd_addr;
    end
    if (wr_en) begin
      mem_r[addr_r] <= ls_nxt;
      fwd_addr_r    <= addr_r;
      fwd_data_r    <= ls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      fwd_vld_r <= 1'b1;
    end
  end

endmodule

// ===== sv/ogsm_col_cell.sv =====
// Window column cell: holds one 7-bit column, shifts it on, sums its weights.
module ogsm_col_cell (
  input  logic                          clk,
  input  ogsm_pkg::cell_ctl_t           ctl,
  input  logic                          col_ok,
  input  logic [1:0]                    adx,
  input  logic [ogsm_pkg::WIN-1:0]      bits_in,
  output logic [ogsm_pkg::WIN-1:0]      bits_out,
  output logic [ogsm_pkg::PSUM_W-1:0]   psum
);
  import ogsm_pkg::*;

  logic [WIN-1:0]    bits_r;
  logic [PSUM_W-1:0] psum_r;
  logic [PSUM_W-1:0] psum_nxt;
  logic [1:0]        ady;
  logic              hit;

  // Weighted sum over the rows of this column that lie inside the map
  always_comb begin
    psum_nxt = '0;
    for (int j = 0; j < WIN; j++) begin
      ady      = 2'((j < HALF_WIN) ? (HALF_WIN - j) : (j - HALF_WIN));
      hit      = bits_r[j] & ctl.row_ok[j] & col_ok;
      psum_nxt = psum_nxt + PSUM_W'({WGT_W{hit}} & weight(ady, adx));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      bits_r <= bits_in;
    end
    if (ctl.calc) begin
      psum_r <= psum_nxt;
    end
  end

  assign bits_out = bits_r;
  assign psum     = psum_r;

endmodule

// ===== sv/occupancy_gaussian_splat_map.sv =====
// Top level: 7x7 Gaussian splat of occupied map cells into a likelihood field.
//
//   port group | dir | contents
//   in_        | in  | tdata: pixel[7:0]; tuser: is_fill
//   out_       | out | tdata: field_value[15:0], row[27:16], col[38:28], 0[39];
//              |     | tlast: frame_last
//   cfg_       | in  | cfg_idx 0 map_width, 1 map_height, 2 occupied_max
//
// One word per cycle in and out while out_tready is high; the line store does one
// read and one write per cycle. A result is computed from the word that completes
// its window, 3 rows plus 3 cells after its own pixel, and passes the line store,
// the column cells and the output register. Reset is synchronous; the line store
// needs no clearing pass. A result held by out_tready low freezes the whole pipeline;
// in_tready is high whenever the output register is empty or being taken.
module occupancy_gaussian_splat_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ogsm_pkg::IN_TDATA_W-1:0]   in_tdata,   // pixel
  input  logic                              in_tuser,   // is_fill
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ogsm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // field_value, row, col, pad
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [ogsm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ogsm_pkg::CFG_W-1:0]        cfg_data
);
  import ogsm_pkg::*;

  // Configuration
  logic [WIDTH_W-1:0]   w_r;
  logic [HEIGHT_W-1:0]  h_r;
  logic [OCC_CFG_W-1:0] omax_r;
  logic [WIDTH_W-1:0]   w_cl;
  logic [HEIGHT_W-1:0]  h_cl;
  logic [WIDTH_CFG_W-1:0]  w_cfg;
  logic [HEIGHT_CFG_W-1:0] h_cfg;

  // Stream counters
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [HEIGHT_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    lag;

  logic en, acc;
  logic occ0, emit0, last0;

  // Pipeline stages
  logic v1_r, v2_r, v3_r, vo_r;
  logic occ1_r, emit1_r, last1_r;
  logic [ROW_W-1:0] orow1_r;
  logic [COL_W-1:0] ocol1_r;
  logic emit2_r, last2_r;
  logic [ROW_W-1:0] orow2_r;
  logic [COL_W-1:0] ocol2_r;
  logic [WIN-1:0]   rowok_nxt, colok_nxt, rowok2_r, colok2_r;
  logic emit3_r, last3_r;
  logic [ROW_W-1:0] orow3_r;
  logic [COL_W-1:0] ocol3_r;

  // Output register
  logic [FIELD_W-1:0]     field_r;
  logic [ROW_FIELD_W-1:0] orow_o_r;
  logic [COL_FIELD_W-1:0] ocol_o_r;
  logic                   last_o_r;

  logic [WIN-1:0]    vcol;
  logic [WIN-1:0]    chain [WIN];
  logic [PSUM_W-1:0] psum [WIN];
  cell_ctl_t         ctl;
  logic [SUM_W-1:0]  total, sat;

  assign en        = !vo_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Register write values, clamped to the legal range
  always_comb begin
    w_cfg = cfg_data[WIDTH_CFG_W-1:0];
    h_cfg = cfg_data[HEIGHT_CFG_W-1:0];
    if (w_cfg == '0) begin
      w_cl = WIDTH_W'(1);
    end else if (32'(w_cfg) > MAX_WIDTH) begin
      w_cl = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_cl = WIDTH_W'(w_cfg);
    end
    if (h_cfg == '0) begin
      h_cl = HEIGHT_W'(1);
    end else if (32'(h_cfg) > MAX_HEIGHT) begin
      h_cl = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_cl = HEIGHT_W'(h_cfg);
    end
  end

  // Per-word bookkeeping at acceptance
  always_comb begin
    occ0  = (in_row_r < h_r) && !in_tuser && (in_tdata[PIXEL_W-1:0] <= omax_r);
    lag   = CNT_W'({w_r, 1'b0}) + CNT_W'(w_r) + CNT_W'(HALF_WIN);
    emit0 = (cnt_r == lag);
    last0 = emit0 && (out_row_r == ROW_W'(h_r - 1'b1))
                  && (out_col_r == COL_W'(w_r - 1'b1));

    in_col_nxt  = in_col_r + 1'b1;
    in_row_nxt  = in_row_r;
    if ((WIDTH_W'(in_col_r) + 1'b1) == w_r) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + 1'b1;
    end
    cnt_nxt     = emit0 ? cnt_r : cnt_r + 1'b1;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit0) begin
      out_col_nxt = out_col_r + 1'b1;
      if ((WIDTH_W'(out_col_r) + 1'b1) == w_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end
    end
    if (last0) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      cnt_nxt     = '0;
    end
  end

  // Configuration and counters; a write to a mapped register restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WIDTH_W'(MAX_WIDTH);
      h_r       <= HEIGHT_W'(MAX_HEIGHT);
      omax_r    <= OCC_DEFAULT;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cnt_r     <= '0;
    end else if (cfg_we && (cfg_idx == REG_MAP_WIDTH || cfg_idx == REG_MAP_HEIGHT ||
                            cfg_idx == REG_OCCUPIED_MAX)) begin
      unique case (cfg_idx)
        REG_MAP_WIDTH:    w_r    <= w_cl;
        REG_MAP_HEIGHT:   h_r    <= h_cl;
        REG_OCCUPIED_MAX: omax_r <= cfg_data[OCC_CFG_W-1:0];
        default:          omax_r <= omax_r;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cnt_r     <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r && emit3_r;
    end
  end

  // Edge masks for the output cell: rows and columns outside the map
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      if (k < HALF_WIN) begin
        rowok_nxt[k] = (orow1_r >= ROW_W'(HALF_WIN - k));
        colok_nxt[k] = (ocol1_r >= COL_W'(HALF_WIN - k));
      end else begin
        rowok_nxt[k] = ((HEIGHT_W'(orow1_r) + HEIGHT_W'(k - HALF_WIN)) < h_r);
        colok_nxt[k] = ((WIDTH_W'(ocol1_r) + WIDTH_W'(k - HALF_WIN)) < w_r);
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      occ1_r   <= occ0;
      emit1_r  <= emit0;
      last1_r  <= last0;
      orow1_r  <= out_row_r;
      ocol1_r  <= out_col_r;
      emit2_r  <= emit1_r;
      last2_r  <= last1_r;
      orow2_r  <= orow1_r;
      ocol2_r  <= ocol1_r;
      rowok2_r <= rowok_nxt;
      colok2_r <= colok_nxt;
      emit3_r  <= emit2_r;
      last3_r  <= last2_r;
      orow3_r  <= orow2_r;
      ocol3_r  <= ocol2_r;
      if (v3_r && emit3_r) begin
        field_r  <= FIELD_W'(sat);
        orow_o_r <= ROW_FIELD_W'(orow3_r);
        ocol_o_r <= COL_FIELD_W'(ocol3_r);
        last_o_r <= last3_r;
      end
    end
  end

  ogsm_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (in_col_r),
    .wr_en   (v1_r && en),
    .occ     (occ1_r),
    .vcol    (vcol)
  );

  // Chain of column cells: newest column enters the last cell
  assign ctl.shift  = v1_r && en;
  assign ctl.calc   = v2_r && en;
  assign ctl.row_ok = rowok2_r;

  for (genvar s = 0; s < WIN; s++) begin : g_cell
    ogsm_col_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .col_ok   (colok2_r[s]),
      .adx      (2'((s < HALF_WIN) ? (HALF_WIN - s) : (s - HALF_WIN))),
      .bits_in  ((s == WIN - 1) ? vcol : chain[(s + 1) % WIN]),
      .bits_out (chain[s]),
      .psum     (psum[s])
    );
  end

  // Column sums added and saturated at 1.0
  always_comb begin
    total = '0;
    for (int k = 0; k < WIN; k++) begin
      total = total + SUM_W'(psum[k]);
    end
    sat = (total > (SUM_W'(1) << FRACTION_BITS)) ? (SUM_W'(1) << FRACTION_BITS) : total;
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, ocol_o_r, orow_o_r, field_r};
  assign out_tlast  = last_o_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the occupancy splat map: directed and random pixel streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ogsm_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 650;
  localparam int unsigned SETTLE_CYCLES = 12;    // output lags its last word
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned WHOLE_FRAME   = 32'hFFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored

  // Q.24 splat taps exp(-(dy^2+dx^2)/4)/5, [|dy|][|dx|]
  localparam int unsigned Q24_TAPS [4][4] = '{
    '{3355443, 2613222, 1234399, 353661},
    '{2613222, 2035179,  961351, 275432},
    '{1234399,  961351,  454110, 130105},
    '{ 353661,  275432,  130105,  37276}
  };

  typedef struct packed {
    logic [15:0] value;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } cell_t;

  typedef struct {
    logic [7:0] pix;
    logic       fill;
    bit         typed;
    cell_t      want;
  } probe_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // pixel[7:0]
  logic                   in_tuser;   // is_fill
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // field_value[15:0], row[27:16], col[38:28], 0[39]
  logic                   out_tlast;  // frame_last
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_data;

  occupancy_gaussian_splat_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  // Field model state
  logic [5:0]  line_bits [MAX_WIDTH];
  logic [48:0] win_bits;
  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [7:0]  occ_r;
  int unsigned in_c, in_r, out_c, out_r;

  // Cells predicted but not yet seen on the output
  cell_t       pending [$];

  // Stimulus knobs and tallies
  bit          steady;       // no input gaps
  bit          hold_req;     // ask the sink for one long hold-off
  int unsigned dense;        // percent of pixels forced occupied
  int unsigned words_in;
  int unsigned cells_checked;
  int unsigned reg_writes;
  int unsigned mismatches;

  // Directed frame: 5x2 map, everything occupied except a fill at (1,4); drain words
  // alternate fill and plain pixels that land past the frame. Cell (0,1) saturates.
  probe_t probes [28] = '{
    '{8'd0,   1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0},
    '{8'd128, 1'b0, 1'b0, '0}, '{8'd1,   1'b0, 1'b0, '0},
    '{8'd254, 1'b0, 1'b0, '0}, '{8'd127, 1'b0, 1'b0, '0},
    '{8'd0,   1'b0, 1'b0, '0}, '{8'd255, 1'b0, 1'b0, '0},
    '{8'd64,  1'b0, 1'b0, '0}, '{8'd0,   1'b1, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0},
    '{8'd0,   1'b0, 1'b1, '{16'h8000, 12'd0, 11'd1, 1'b0}},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0},
    '{8'd255, 1'b1, 1'b0, '0}, '{8'd0,   1'b0, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned span_cols();
    if (width_r == 0) return 1;
    if (width_r > MAX_WIDTH) return MAX_WIDTH;
    return width_r;
  endfunction

  function automatic int unsigned span_rows();
    if (height_r == 0) return 1;
    if (height_r > MAX_HEIGHT) return MAX_HEIGHT;
    return height_r;
  endfunction

  function automatic void rewind();
    in_c  = 0;
    in_r  = 0;
    out_c = 0;
    out_r = 0;
  endfunction

  // Advance the field model by one word; returns 1 when a cell comes out
  function automatic bit splat_step(input logic [7:0] pix, input logic fill,
                                    output cell_t res);
    int unsigned     w, h, c, orow, ocol, sum, sh, rnd, ady, adx;
    int              s, j, dx, dy, cx, ry;
    logic            occ;
    logic [5:0]      ls;
    logic [6:0]      vcol;
    longint unsigned p, lag;
    w   = span_cols();
    h   = span_rows();
    occ = (in_r < h) && !fill && (pix <= occ_r);
    c   = (in_c < w) ? in_c : 0;
    ls  = line_bits[c];
    // oldest row at bit 0, incoming row at bit 6
    for (j = 0; j < 6; j++) vcol[j] = ls[5-j];
    vcol[6]      = occ;
    line_bits[c] = {ls[4:0], occ};
    win_bits     = {vcol, win_bits[48:7]};
    p   = in_r;
    p   = p * w + c;
    lag = 3 * w + 3;
    in_c = c + 1;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
    end
    if (p < lag) return 1'b0;

    orow = out_r;
    ocol = out_c;
    sum  = 0;
    sh   = 24 - FRACTION_BITS;
    rnd  = (sh == 0) ? 0 : (1 << (sh - 1));
    for (s = 0; s < 7; s++) begin
      dx = s - 3;
      cx = int'(ocol) + dx;
      if (cx < 0 || cx >= int'(w)) continue;
      adx = (dx < 0) ? -dx : dx;
      for (j = 0; j < 7; j++) begin
        dy = j - 3;
        ry = int'(orow) + dy;
        if (ry < 0 || ry >= int'(h)) continue;
        ady = (dy < 0) ? -dy : dy;
        if (win_bits[s*7+j]) sum += (Q24_TAPS[ady][adx] + rnd) >> sh;
      end
    end
    if (sum > (1 << FRACTION_BITS)) sum = 1 << FRACTION_BITS;

    res.value = sum[15:0];
    res.row   = orow[11:0];
    res.col   = ocol[10:0];
    res.last  = (orow == h - 1) && (ocol == w - 1);
    if (res.last) begin
      rewind();
    end else begin
      out_c = ocol + 1;
      if (out_c >= w) begin
        out_c = 0;
        out_r = orow + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias toward the threshold and its neighbor above
  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return occ_r;
    if (r < 16) return occ_r + 8'd1;
    if (r < 16 + dense) return 8'($urandom_range(0, occ_r));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [7:0] pix, input logic fill,
                           input bit typed = 1'b0, input cell_t want = '0);
    int unsigned gap;
    cell_t       res;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fill;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_in++;
    if (splat_step(pix, fill, res)) pending.push_back(typed ? want : res);
  endtask

  // Stop sending, let every expected cell out, then give the pipeline time to empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_we after the last of a burst of writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_MAP_WIDTH:    width_r  = data[11:0];
      REG_MAP_HEIGHT:   height_r = data[12:0];
      REG_OCCUPIED_MAX: occ_r    = data[7:0];
      default: ;
    endcase
    if (idx != REG_SPARE) rewind();
  endtask

  task automatic setup(input bit [2:0] mask, input logic [CFG_W-1:0] wv, hv, ov);
    settle();
    if (mask[0]) write_reg(REG_MAP_WIDTH, wv);
    if (mask[1]) write_reg(REG_MAP_HEIGHT, hv);
    if (mask[2]) write_reg(REG_OCCUPIED_MAX, ov);
    cfg_we <= 1'b0;
  endtask

  // One frame plus its drain words, optionally cut short or paused midway
  task automatic send_frame(input int unsigned stop_at, input bit pause);
    int unsigned w, h, cells, total, k, pause_at;
    logic [7:0]  pix;
    logic        fill;
    w        = span_cols();
    h        = span_rows();
    cells    = w * h;
    total    = cells + 3 * w + 3;
    pause_at = pause ? $urandom_range(0, total - 1) : total;
    for (k = 0; k < total && k < stop_at; k++) begin
      if (k == pause_at) begin
        settle();
        if ($urandom_range(0, 1) != 0) begin
          write_reg(REG_SPARE, CFG_W'($urandom));
          cfg_we <= 1'b0;
        end
      end
      if (k < cells) begin
        pix  = pick_pixel();
        fill = ($urandom_range(0, 99) < 6);
      end else begin
        pix  = 8'($urandom_range(0, 255));
        fill = 1'($urandom_range(0, 1));
      end
      send_word(pix, fill);
    end
  endtask

  // Result sink: random ready patterns plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left, stall_left, mode, mode_left;
    logic        rdy;
    out_tready = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (mode == 0) begin
        rdy = 1'b1;
      end else if (mode == 1) begin
        rdy = ($urandom_range(0, 3) != 0);
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 19) == 0) begin
          stall_left = $urandom_range(8, 40);
          rdy        = 1'b0;
        end
      end
      out_tready <= rdy;
    end
  end

  // Compare each output word with the oldest predicted cell
  always @(posedge clk) begin : field_check
    cell_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected word: field_value %0d row %0d col %0d",
               out_tdata[15:0], out_tdata[27:16], out_tdata[38:28]);
        mismatches++;
      end else begin
        want = pending.pop_front();
        cells_checked++;
        if (out_tdata[15:0] !== want.value) begin
          $error("field_value: expected %0d, got %0d", want.value, out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[27:16] !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_tdata[27:16]);
          mismatches++;
        end
        if (out_tdata[38:28] !== want.col) begin
          $error("col: expected %0d, got %0d", want.col, out_tdata[38:28]);
          mismatches++;
        end
        if (out_tdata[39] !== 1'b0) begin
          $error("pad: expected 0, got %0b", out_tdata[39]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any accepted input or output word or register write
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** occupancy_gaussian_splat_map: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned  start, phase, frames, r;
    bit [2:0]     mask;
    logic [CFG_W-1:0] wv, hv, ov;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_MAP_WIDTH;
    cfg_data  = '0;
    steady    = 1'b1;
    hold_req  = 1'b0;
    dense     = 30;
    words_in  = 0;
    cells_checked = 0;
    reg_writes    = 0;
    mismatches    = 0;
    foreach (line_bits[i]) line_bits[i] = '0;
    win_bits = '0;
    width_r  = 12'd2048;
    height_r = 13'd4096;
    occ_r    = OCC_DEFAULT;
    rewind();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame, all gray values occupied
    setup(3'b111, 13'd5, 13'd2, 13'd255);
    foreach (probes[i]) send_word(probes[i].pix, probes[i].fill, probes[i].typed, probes[i].want);

    // Random map setups, mostly small maps with complete frames
    start = words_in;
    phase = 0;
    while (words_in - start < RANDOM_WORDS) begin
      r    = $urandom_range(0, 99);
      wv   = (r < 70) ? 13'($urandom_range(1, 8)) :
             (r < 95) ? 13'($urandom_range(9, 40)) : 13'($urandom_range(41, 200));
      hv   = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(1, 6)) :
                                            13'($urandom_range(7, 20));
      r    = $urandom_range(0, 99);
      ov   = (r < 15) ? 13'd0 : (r < 30) ? 13'd255 : (r < 45) ? 13'd124 :
             13'($urandom_range(0, 255));
      mask = 3'($urandom_range(1, 7));
      if (phase == 0) begin
        // block must fill up while the sink holds off
        mask = 3'b111;
        wv   = 13'd6;
        hv   = 13'd5;
      end
      setup(mask, wv, hv, ov);
      dense  = $urandom_range(0, 60);
      steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_req = 1'b1;
      frames = $urandom_range(1, 2);
      repeat (frames) send_frame(WHOLE_FRAME, (phase == 1) || ($urandom_range(0, 4) == 0));
      if ($urandom_range(0, 3) == 0) send_frame($urandom_range(1, 40), 1'b0);
      phase++;
    end

    // Register extremes: clamped low, widest row, tallest column, reset values
    // (the large maps only get the head of a frame)
    steady = 1'b0;
    dense  = 40;
    setup(3'b111, 13'd0, 13'd0, 13'd0);
    repeat (3) send_frame(WHOLE_FRAME, 1'b0);
    setup(3'b111, 13'd4095, 13'd1, 13'd255);
    send_frame(40, 1'b0);
    setup(3'b111, 13'd1, 13'd8191, 13'd124);
    send_frame(60, 1'b0);
    setup(3'b111, 13'd2048, 13'd4096, 13'd124);
    send_frame(40, 1'b0);

    settle();
    $display("%0d words sent over %0d map setups, %0d register writes, %0d cells checked",
             words_in, phase + 5, reg_writes, cells_checked);
    $display("  incl. saturation, fill and past-frame words, sink hold-off, width/height clamps");
    if (mismatches == 0) begin
      $display("** occupancy_gaussian_splat_map: PASSED **");
    end else begin
      $display("** occupancy_gaussian_splat_map: FAILED **");
    end
    $finish;
  end

endmodule
